// ===== hw/rtl/rsc_pkg.sv =====
// Shared constants, types and modular arithmetic helpers for the GF(929) check word generator.
package rsc_pkg;

  localparam int NCHK   = 64;
  localparam int CW_W   = 10;
  localparam int LVL_W  = 3;
  localparam int K_W    = $clog2(NCHK + 1);
  localparam int CNT_W  = $clog2(NCHK);
  localparam int NLVL   = 2 ** LVL_W;

  localparam logic [CW_W-1:0] PRIME     = 10'd929;
  localparam logic [CW_W-1:0] ROOT_BASE = 10'd3;
  localparam logic [20:0]     RECIP     = 21'd1155803;
  localparam int              RECIP_SH  = 30;

  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_QUOT,
    ST_UPD,
    ST_EMIT
  } st_e;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INIT,
    OP_MUL,
    OP_QUOT,
    OP_GEN,
    OP_REM,
    OP_ROT
  } cell_op_e;

  typedef struct packed {
    cell_op_e        op;
    logic [CW_W-1:0] mul_a;
  } cell_ctrl_t;

  function automatic logic [CW_W-1:0] fold_mod(input logic [CW_W:0] v);
    logic [CW_W:0] t;
    t = v - {1'b0, PRIME};
    return (v >= {1'b0, PRIME}) ? t[CW_W-1:0] : v[CW_W-1:0];
  endfunction

  function automatic logic [CW_W-1:0] mod_sub(input logic [CW_W-1:0] a,
                                               input logic [CW_W-1:0] b);
    logic [CW_W:0] t;
    t = {1'b0, a} + {1'b0, PRIME} - {1'b0, b};
    return fold_mod(t);
  endfunction

  function automatic logic [CW_W-1:0] mul3_mod(input logic [CW_W-1:0] r);
    logic [CW_W+1:0] t;
    logic [CW_W+1:0] p1;
    logic [CW_W+1:0] p2;
    t  = {2'b00, r} + {1'b0, r, 1'b0};
    p1 = {2'b00, PRIME};
    p2 = {1'b0, PRIME, 1'b0};
    if (t >= p2) begin
      t = t - p2;
    end else if (t >= p1) begin
      t = t - p1;
    end
    return t[CW_W-1:0];
  endfunction

  function automatic logic [K_W-1:0] check_count(input logic [LVL_W-1:0] lvl);
    logic [NLVL+1:0] k;
    k = {{(NLVL+1){1'b0}}, 1'b1} << ({1'b0, lvl} + 4'd1);
    if (k > (NLVL + 2)'(NCHK)) begin
      k = (NLVL + 2)'(NCHK);
    end
    return K_W'(k);
  endfunction

  function automatic int top_lane(input int lvl);
    int k;
    k = 2 << lvl;
    if (k > NCHK) begin
      k = NCHK;
    end
    return k - 1;
  endfunction

endpackage

// ===== hw/rtl/rsc_in_if.sv =====
// Input item channel: kind and codeword with valid/ready.
interface rsc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [9:0] codeword;

  modport source (output valid, output kind, output codeword, input ready);
  modport sink   (input valid, input kind, input codeword, output ready);
endinterface

// ===== hw/rtl/rsc_out_if.sv =====
// Result channel: check word and last flag with valid/ready.
interface rsc_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] check_word;
  logic       last_word;

  modport source (output valid, output check_word, output last_word, input ready);
  modport sink   (input valid, input check_word, input last_word, output ready);
endinterface

// ===== hw/rtl/rsc_cfg_if.sv =====
// Configuration write channel carrying the ecc level.
interface rsc_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] ecc_level;

  modport source (output valid, output ecc_level, input ready);
  modport sink   (input valid, input ecc_level, output ready);
endinterface

// ===== hw/rtl/rsc_cell.sv =====
// One lane of the chain: generator coefficient, remainder word and a multiply-reduce unit.
module rsc_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rsc_pkg::cell_ctrl_t        ctrl_i,
  input  logic                       en_i,
  input  logic                       seed_i,
  input  logic [rsc_pkg::CW_W-1:0]   gen_prev_i,
  input  logic [rsc_pkg::CW_W-1:0]   rem_prev_i,
  output logic [rsc_pkg::CW_W-1:0]   gen_o,
  output logic [rsc_pkg::CW_W-1:0]   rem_o
);

  logic [rsc_pkg::CW_W-1:0]   gen_q, gen_d;
  logic [rsc_pkg::CW_W-1:0]   rem_q, rem_d;
  logic [2*rsc_pkg::CW_W-1:0] prod_q, prod_d;
  logic [rsc_pkg::CW_W-1:0]   quot_q, quot_d;
  logic [40:0]                quot_full;
  logic [2*rsc_pkg::CW_W-1:0] qm;
  logic [rsc_pkg::CW_W:0]     resid_raw;
  logic [rsc_pkg::CW_W-1:0]   resid;

  assign quot_full = {21'd0, prod_q} * {20'd0, rsc_pkg::RECIP};
  assign qm        = {10'd0, quot_q} * {10'd0, rsc_pkg::PRIME};
  assign resid_raw = prod_q[rsc_pkg::CW_W:0] - qm[rsc_pkg::CW_W:0];
  assign resid     = rsc_pkg::fold_mod(resid_raw);

  always_comb begin
    gen_d  = gen_q;
    rem_d  = rem_q;
    prod_d = prod_q;
    quot_d = quot_q;
    case (ctrl_i.op)
      rsc_pkg::OP_INIT: begin
        gen_d = seed_i ? 10'd1 : 10'd0;
        rem_d = '0;
      end
      rsc_pkg::OP_MUL: begin
        prod_d = {10'd0, ctrl_i.mul_a} * {10'd0, gen_q};
      end
      rsc_pkg::OP_QUOT: begin
        quot_d = quot_full[rsc_pkg::RECIP_SH+rsc_pkg::CW_W-1:rsc_pkg::RECIP_SH];
      end
      rsc_pkg::OP_GEN: begin
        if (en_i) begin
          gen_d = rsc_pkg::mod_sub(gen_prev_i, resid);
        end
      end
      rsc_pkg::OP_REM: begin
        if (en_i) begin
          rem_d = rsc_pkg::mod_sub(rem_prev_i, resid);
        end
      end
      rsc_pkg::OP_ROT: begin
        if (en_i) begin
          rem_d = rem_prev_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gen_q  <= gen_d;
    prod_q <= prod_d;
    quot_q <= quot_d;
  end

  assign gen_o = gen_q;
  assign rem_o = rem_q;

endmodule

// ===== hw/rtl/reed_solomon_check_gf929.sv =====
// Top level: PDF417 Reed-Solomon check word generator over GF(929).
// A start item is accepted and then takes one pass per generator root, each root being
// one multiply, reduce and update pass through the per-lane multiply-reduce unit of
// every cell in the chain. A data codeword is accepted and then takes one such pass; a
// codeword above 928 or an unknown kind is only accepted. A finish item is accepted and
// then yields one check word per cycle while the output is not stalled, as the remainder
// rotates through the first k cells; the input is ready again once the last word sits in
// the output register. k = 2^(ecc_level+1), capped at 64.
module reed_solomon_check_gf929 (
  input  logic      clk_i,
  input  logic      rst_ni,
  rsc_in_if.sink    in_i,
  rsc_out_if.source out_o,
  rsc_cfg_if.sink   cfg_i
);

  localparam int N = rsc_pkg::NCHK;

  rsc_pkg::st_e                state_q, state_d;
  logic [rsc_pkg::LVL_W-1:0]   level_q;
  logic [rsc_pkg::CW_W-1:0]    opa_q;
  logic                        build_q;
  logic [rsc_pkg::K_W-1:0]     step_q;
  logic [rsc_pkg::CNT_W-1:0]   emit_cnt_q;
  logic                        out_valid_q;
  logic [rsc_pkg::CW_W-1:0]    out_word_q;
  logic                        out_last_q;

  logic [rsc_pkg::K_W-1:0]     k;
  logic [rsc_pkg::CNT_W-1:0]   k_m1;
  logic                        in_xfer;
  logic                        cw_ok;
  logic                        load;
  logic                        emit_last;
  logic [rsc_pkg::CW_W-1:0]    rem_top;
  logic [rsc_pkg::CW_W-1:0]    fb;
  rsc_pkg::cell_ctrl_t         ctrl;

  logic [rsc_pkg::CW_W-1:0]    gen_w [N];
  logic [rsc_pkg::CW_W-1:0]    rem_w [N];

  assign k         = rsc_pkg::check_count(level_q);
  assign k_m1      = rsc_pkg::CNT_W'(k - 1'b1);
  assign in_xfer   = in_i.valid && in_i.ready;
  assign cw_ok     = in_i.codeword < rsc_pkg::PRIME;
  assign load      = (state_q == rsc_pkg::ST_EMIT) && (!out_valid_q || out_o.ready);
  assign emit_last = emit_cnt_q == k_m1;
  assign fb        = rsc_pkg::fold_mod({1'b0, in_i.codeword} + {1'b0, rem_top});

  always_comb begin
    rem_top = rem_w[N-1];
    for (int l = 0; l < rsc_pkg::NLVL; l++) begin
      if (level_q == rsc_pkg::LVL_W'(l)) begin
        rem_top = rem_w[rsc_pkg::top_lane(l)];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      rsc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          case (in_i.kind)
            rsc_pkg::KIND_START:  state_d = rsc_pkg::ST_MUL;
            rsc_pkg::KIND_DATA:   state_d = cw_ok ? rsc_pkg::ST_MUL : rsc_pkg::ST_IDLE;
            rsc_pkg::KIND_FINISH: state_d = rsc_pkg::ST_EMIT;
            default:              state_d = rsc_pkg::ST_IDLE;
          endcase
        end
      end
      rsc_pkg::ST_MUL:  state_d = rsc_pkg::ST_QUOT;
      rsc_pkg::ST_QUOT: state_d = rsc_pkg::ST_UPD;
      rsc_pkg::ST_UPD: begin
        state_d = (build_q && step_q != k) ? rsc_pkg::ST_MUL : rsc_pkg::ST_IDLE;
      end
      rsc_pkg::ST_EMIT: begin
        if (load && emit_last) begin
          state_d = rsc_pkg::ST_IDLE;
        end
      end
      default: state_d = rsc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.op    = rsc_pkg::OP_HOLD;
    ctrl.mul_a = opa_q;
    in_i.ready = 1'b0;
    case (state_q)
      rsc_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid && in_i.kind == rsc_pkg::KIND_START) begin
          ctrl.op = rsc_pkg::OP_INIT;
        end
      end
      rsc_pkg::ST_MUL:  ctrl.op = rsc_pkg::OP_MUL;
      rsc_pkg::ST_QUOT: ctrl.op = rsc_pkg::OP_QUOT;
      rsc_pkg::ST_UPD:  ctrl.op = build_q ? rsc_pkg::OP_GEN : rsc_pkg::OP_REM;
      rsc_pkg::ST_EMIT: ctrl.op = load ? rsc_pkg::OP_ROT : rsc_pkg::OP_HOLD;
      default:          ctrl.op = rsc_pkg::OP_HOLD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rsc_pkg::ST_IDLE;
      level_q     <= '0;
      build_q     <= 1'b0;
      step_q      <= '0;
      emit_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        level_q <= cfg_i.ecc_level;
      end
      if (in_xfer && in_i.kind == rsc_pkg::KIND_START) begin
        build_q <= 1'b1;
        step_q  <= rsc_pkg::K_W'(1);
      end else if (in_xfer && in_i.kind == rsc_pkg::KIND_DATA) begin
        build_q <= 1'b0;
      end else if (state_q == rsc_pkg::ST_UPD && build_q && step_q != k) begin
        step_q <= step_q + 1'b1;
      end
      if (in_xfer && in_i.kind == rsc_pkg::KIND_FINISH) begin
        emit_cnt_q <= '0;
      end else if (load) begin
        emit_cnt_q <= emit_cnt_q + 1'b1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && in_i.kind == rsc_pkg::KIND_START) begin
      opa_q <= rsc_pkg::ROOT_BASE;
    end else if (in_xfer && in_i.kind == rsc_pkg::KIND_DATA) begin
      opa_q <= fb;
    end else if (state_q == rsc_pkg::ST_UPD && build_q && step_q != k) begin
      opa_q <= rsc_pkg::mul3_mod(opa_q);
    end
    if (load) begin
      out_word_q <= rsc_pkg::mod_sub('0, rem_top);
      out_last_q <= emit_last;
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_cell
    logic [rsc_pkg::CW_W-1:0] gen_prev;
    logic [rsc_pkg::CW_W-1:0] rem_prev;
    if (j == 0) begin : g_head
      assign gen_prev = '0;
      assign rem_prev = (ctrl.op == rsc_pkg::OP_ROT) ? rem_top : '0;
    end else begin : g_body
      assign gen_prev = gen_w[j-1];
      assign rem_prev = rem_w[j-1];
    end
    rsc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .en_i       (rsc_pkg::K_W'(j) < k),
      .seed_i     (j == 0),
      .gen_prev_i (gen_prev),
      .rem_prev_i (rem_prev),
      .gen_o      (gen_w[j]),
      .rem_o      (rem_w[j])
    );
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.check_word = out_word_q;
  assign out_o.last_word  = out_last_q;
  assign cfg_i.ready      = 1'b1;

endmodule

// ===== hw/rtl/rsc_checker.sv =====
// Port-level assertions for the check word generator, bound to the top level.
module rsc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [1:0] in_kind_i,
  input logic [9:0] in_codeword_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [9:0] out_check_word_i,
  input logic       out_last_word_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_check_word_i) && $stable(out_last_word_i))
    else $error("stalled result changed");

  a_word_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_check_word_i <= 10'd928)
    else $error("check word out of field range");

  a_finish_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_kind_i == rsc_pkg::KIND_FINISH |=> !in_ready_i)
    else $error("input taken during check word emission");

  a_data_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_kind_i == rsc_pkg::KIND_DATA && in_codeword_i <= 10'd928
    |=> !in_ready_i)
    else $error("input taken during remainder update");

endmodule

bind reed_solomon_check_gf929 rsc_checker u_rsc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .in_kind_i        (in_i.kind),
  .in_codeword_i    (in_i.codeword),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_check_word_i (out_o.check_word),
  .out_last_word_i  (out_o.last_word)
);
